### hw/rtl/nmea_rmc_sentence_parser_unit_macros.svh
// Assertion macros shared by the NMEA RMC parser RTL.
`ifndef NMEA_RMC_SENTENCE_PARSER_UNIT_MACROS_SVH
`define NMEA_RMC_SENTENCE_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: cons must hold whenever ante holds.
`define NMEA_RMC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define NMEA_RMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define NMEA_RMC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define NMEA_RMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### hw/rtl/nmea_rmc_pkg.sv
// Types, constants and helper functions of the NMEA RMC sentence parser.
package nmea_rmc_pkg;

   // Character codes
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_POINT  = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_E      = 8'h45;
   localparam logic [7:0] CHAR_N      = 8'h4E;

   // Field indexes of the decoded RMC fields
   localparam logic [4:0] FIELD_TIME     = 5'd1;
   localparam logic [4:0] FIELD_LAT      = 5'd3;
   localparam logic [4:0] FIELD_LAT_HEMI = 5'd4;
   localparam logic [4:0] FIELD_LON      = 5'd5;
   localparam logic [4:0] FIELD_LON_HEMI = 5'd6;
   localparam logic [4:0] FIELD_SPEED    = 5'd7;
   localparam logic [4:0] FIELD_COURSE   = 5'd8;
   localparam logic [4:0] FIELD_DATE     = 5'd9;

   // Field count limits
   localparam int DEFAULT_MAX_FIELDS = 20;
   localparam int FIELD_COUNT_LIMIT  = 31;

   // Accumulator caps and fraction digit limits
   localparam logic [23:0] MINUTES_CAP        = 24'd9999999;
   localparam logic [23:0] MILLIKNOT_CAP      = 24'hFFFFFF;
   localparam logic [15:0] COURSE_CAP         = 16'hFFFF;
   localparam logic [2:0]  MINUTE_FRAC_DIGITS = 3'd5;
   localparam logic [2:0]  KNOT_FRAC_DIGITS   = 3'd3;
   localparam logic [3:0]  CHAR_POS_MAX       = 4'd15;

   // Output scaling constants
   localparam logic [11:0] YEAR_BASE      = 12'd2000;
   localparam logic [16:0] DEG_SCALE      = 17'd100000;
   localparam logic [10:0] KMH_NUMERATOR  = 11'd1852;
   localparam logic [19:0] KMH_ROUND      = 20'd500000;
   // floor(x/60) = (x * MIN60_RECIP) >> MIN60_SHIFT for x < 2^24
   localparam logic [24:0] MIN60_RECIP    = 25'd17895698;
   localparam int          MIN60_SHIFT    = 30;
   // floor(y/15625) = (y * KMH_RECIP) >> KMH_SHIFT for y < 2^29
   localparam logic [29:0] KMH_RECIP      = 30'd562949954;
   localparam int          KMH_SHIFT      = 43;
   localparam int          KMH_PRESHIFT   = 6;

   localparam int RSP_DATA_W = 136;

   // Decoded field values of one sentence
   typedef struct packed {
      logic [23:0] time_digits;
      logic [23:0] date_digits;
      logic [6:0]  lat_degrees;
      logic [23:0] lat_minutes;
      logic [9:0]  lon_degrees;
      logic [23:0] lon_minutes;
      logic [1:0]  hemisphere;
      logic [23:0] speed_mk;
      logic [15:0] course;
   } nmea_rmc_fix_type;

   // Full parser state
   typedef struct packed {
      logic [4:0]       field_number;
      logic [3:0]       char_position;
      logic [2:0]       fraction_digit_count;
      logic             seen_point;
      nmea_rmc_fix_type fix;
   } nmea_rmc_state_type;

   // Result of one accumulator step
   typedef struct packed {
      logic [23:0] acc;
      logic        seen;
      logic [2:0]  frac;
   } nmea_rmc_acc_type;

   // Intermediate values between the two result stages
   typedef struct packed {
      logic [6:0]  utc_hour;
      logic [6:0]  utc_minute;
      logic [6:0]  utc_second;
      logic [6:0]  date_day;
      logic [6:0]  date_month;
      logic [11:0] date_year;
      logic [23:0] lat_deg_e5;
      logic [17:0] lat_min_e5;
      logic        lat_is_north;
      logic [26:0] lon_deg_e5;
      logic [17:0] lon_min_e5;
      logic        lon_is_east;
      logic [28:0] speed_scaled;
      logic [15:0] course_deg;
   } nmea_rmc_mid_type;

   // One result beat
   typedef struct packed {
      logic [6:0]         utc_hour;
      logic [6:0]         utc_minute;
      logic [6:0]         utc_second;
      logic [6:0]         date_day;
      logic [6:0]         date_month;
      logic [11:0]        date_year;
      logic signed [24:0] latitude;
      logic               lat_is_north;
      logic signed [27:0] longitude;
      logic               lon_is_east;
      logic [15:0]        speed_kmh;
      logic [15:0]        course_deg;
   } nmea_rmc_result_type;

   // Digit value of a character; anything but 0-9 reads as zero
   function automatic logic [3:0] digit_of(logic [7:0] c);
      logic [7:0] diff;
      diff = c - CHAR_ZERO;
      return (c >= CHAR_ZERO && c <= CHAR_NINE) ? diff[3:0] : 4'd0;
   endfunction

   // Weight of the next minute fraction digit, in 1e-5 minute
   function automatic logic [16:0] minute_scale(logic [2:0] frac);
      logic [16:0] s;
      unique case (frac)
         3'd0:    s = 17'd10000;
         3'd1:    s = 17'd1000;
         3'd2:    s = 17'd100;
         3'd3:    s = 17'd10;
         3'd4:    s = 17'd1;
         default: s = 17'd0;
      endcase
      return s;
   endfunction

   // Weight of the next knot fraction digit, in 1e-3 knot
   function automatic logic [6:0] knot_scale(logic [2:0] frac);
      logic [6:0] s;
      unique case (frac)
         3'd0:    s = 7'd100;
         3'd1:    s = 7'd10;
         3'd2:    s = 7'd1;
         default: s = 7'd0;
      endcase
      return s;
   endfunction

   // Minutes accumulator step, units of 1e-5 minute, saturating
   function automatic nmea_rmc_acc_type accumulate_minutes(logic [23:0] acc,
         logic [7:0] c, logic seen, logic [2:0] frac);
      nmea_rmc_acc_type r;
      logic [27:0]      v;
      logic [3:0]       d;
      r.acc  = acc;
      r.seen = seen;
      r.frac = frac;
      d      = digit_of(c);
      v      = '0;
      if (c == CHAR_POINT && !seen) begin
         r.seen = 1'b1;
      end else if (!seen) begin
         v     = 28'(acc) * 28'd10 + 28'(d) * 28'(DEG_SCALE);
         r.acc = (v > 28'(MINUTES_CAP)) ? MINUTES_CAP : v[23:0];
      end else if (frac < MINUTE_FRAC_DIGITS) begin
         v      = 28'(acc) + 28'(d) * 28'(minute_scale(frac));
         r.frac = frac + 3'd1;
         r.acc  = (v > 28'(MINUTES_CAP)) ? MINUTES_CAP : v[23:0];
      end
      return r;
   endfunction

   // Speed accumulator step, units of 1e-3 knot, saturating
   function automatic nmea_rmc_acc_type accumulate_knots(logic [23:0] acc,
         logic [7:0] c, logic seen, logic [2:0] frac);
      nmea_rmc_acc_type r;
      logic [27:0]      v;
      logic [3:0]       d;
      r.acc  = acc;
      r.seen = seen;
      r.frac = frac;
      d      = digit_of(c);
      v      = '0;
      if (c == CHAR_POINT && !seen) begin
         r.seen = 1'b1;
      end else if (!seen) begin
         v     = 28'(acc) * 28'd10 + 28'(d) * 28'd1000;
         r.acc = (v > 28'(MILLIKNOT_CAP)) ? MILLIKNOT_CAP : v[23:0];
      end else if (frac < KNOT_FRAC_DIGITS) begin
         v      = 28'(acc) + 28'(d) * 28'(knot_scale(frac));
         r.frac = frac + 3'd1;
         r.acc  = (v > 28'(MILLIKNOT_CAP)) ? MILLIKNOT_CAP : v[23:0];
      end
      return r;
   endfunction

   // tens*10 + units of a digit pair
   function automatic logic [6:0] pair_value(logic [3:0] tens, logic [3:0] units);
      logic [7:0] v;
      v = 8'(tens) * 8'd10 + 8'(units);
      return v[6:0];
   endfunction

endpackage

### hw/rtl/nmea_rmc_field_tracker.sv
// Byte-by-byte field tracking and digit accumulation for the RMC parser.
`include "nmea_rmc_sentence_parser_unit_macros.svh"

module nmea_rmc_field_tracker import nmea_rmc_pkg::*; #(
   parameter int MAX_FIELDS = DEFAULT_MAX_FIELDS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic             in_ready,
   input  logic [7:0]       char_byte,
   input  logic             last_byte,
   output logic             fix_valid,
   output nmea_rmc_fix_type fix
);

   localparam logic [4:0] FieldCap =
      (MAX_FIELDS > FIELD_COUNT_LIMIT) ? 5'(FIELD_COUNT_LIMIT) : 5'(MAX_FIELDS);

   nmea_rmc_state_type state_ff;
   nmea_rmc_state_type state_in;
   nmea_rmc_state_type state_upd;

   nmea_rmc_acc_type lat_acc;
   nmea_rmc_acc_type lon_acc;
   nmea_rmc_acc_type spd_acc;
   logic [3:0]       digit;
   logic [19:0]      course_sum;
   logic [4:0]       nibble_base;
   logic             accept;

   assign accept      = in_valid && in_ready;
   assign digit       = digit_of(char_byte);
   assign nibble_base = {state_ff.char_position[2:0], 2'b00};
   assign course_sum  = 20'(state_ff.fix.course) * 20'd10 + 20'(digit);

   // Candidate accumulator steps for the numeric fields
   assign lat_acc = accumulate_minutes(state_ff.fix.lat_minutes, char_byte,
                                       state_ff.seen_point, state_ff.fraction_digit_count);
   assign lon_acc = accumulate_minutes(state_ff.fix.lon_minutes, char_byte,
                                       state_ff.seen_point, state_ff.fraction_digit_count);
   assign spd_acc = accumulate_knots(state_ff.fix.speed_mk, char_byte,
                                     state_ff.seen_point, state_ff.fraction_digit_count);

   // State after this byte
   always_comb begin
      state_upd = state_ff;
      if (char_byte == CHAR_DOLLAR) begin
         state_upd = '0;
      end else if (char_byte == CHAR_COMMA || char_byte == CHAR_STAR) begin
         if (state_ff.field_number < FieldCap) begin
            state_upd.field_number = state_ff.field_number + 5'd1;
         end
         state_upd.char_position        = '0;
         state_upd.fraction_digit_count = '0;
         state_upd.seen_point           = 1'b0;
      end else if (state_ff.field_number < FieldCap) begin
         unique case (state_ff.field_number)
            FIELD_TIME: begin
               if (state_ff.char_position < 4'd6) begin
                  state_upd.fix.time_digits[nibble_base +: 4] =
                     state_ff.fix.time_digits[nibble_base +: 4] | digit;
               end
            end
            FIELD_DATE: begin
               if (state_ff.char_position < 4'd6) begin
                  state_upd.fix.date_digits[nibble_base +: 4] =
                     state_ff.fix.date_digits[nibble_base +: 4] | digit;
               end
            end
            FIELD_LAT: begin
               if (state_ff.char_position < 4'd2) begin
                  state_upd.fix.lat_degrees = state_ff.fix.lat_degrees * 7'd10 + 7'(digit);
               end else begin
                  state_upd.fix.lat_minutes      = lat_acc.acc;
                  state_upd.seen_point           = lat_acc.seen;
                  state_upd.fraction_digit_count = lat_acc.frac;
               end
            end
            FIELD_LON: begin
               if (state_ff.char_position < 4'd3) begin
                  state_upd.fix.lon_degrees = state_ff.fix.lon_degrees * 10'd10 + 10'(digit);
               end else begin
                  state_upd.fix.lon_minutes      = lon_acc.acc;
                  state_upd.seen_point           = lon_acc.seen;
                  state_upd.fraction_digit_count = lon_acc.frac;
               end
            end
            FIELD_LAT_HEMI: begin
               if (state_ff.char_position == 4'd0 && char_byte == CHAR_N) begin
                  state_upd.fix.hemisphere[0] = 1'b1;
               end
            end
            FIELD_LON_HEMI: begin
               if (state_ff.char_position == 4'd0 && char_byte == CHAR_E) begin
                  state_upd.fix.hemisphere[1] = 1'b1;
               end
            end
            FIELD_SPEED: begin
               state_upd.fix.speed_mk         = spd_acc.acc;
               state_upd.seen_point           = spd_acc.seen;
               state_upd.fraction_digit_count = spd_acc.frac;
            end
            FIELD_COURSE: begin
               if (char_byte == CHAR_POINT) begin
                  state_upd.seen_point = 1'b1;
               end else if (!state_ff.seen_point) begin
                  state_upd.fix.course =
                     (course_sum > 20'(COURSE_CAP)) ? COURSE_CAP : course_sum[15:0];
               end
            end
            default: begin
            end
         endcase
         if (state_ff.char_position < CHAR_POS_MAX) begin
            state_upd.char_position = state_ff.char_position + 4'd1;
         end
      end
   end

   // Last byte hands the fix on and clears the state
   always_comb begin
      if (accept) begin
         state_in = last_byte ? '0 : state_upd;
      end else begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign fix_valid = accept && last_byte;
   assign fix       = state_upd.fix;

   `NMEA_RMC_ASSERT_NEXT(a_last_clears_state, clock, reset, fix_valid,
      state_ff.field_number == 5'd0 && state_ff.fix == '0, "state not cleared after last byte")
   `NMEA_RMC_ASSERT_IMPLY(a_frac_needs_point, clock, reset, !state_ff.seen_point,
      state_ff.fraction_digit_count == 3'd0, "fraction digits counted without a point")
   `NMEA_RMC_ASSERT_IMPLY(a_field_capped, clock, reset, 1'b1,
      state_ff.field_number <= FieldCap, "field count past its cap")

endmodule

### hw/rtl/nmea_rmc_result_calc.sv
// Two-stage conversion of a captured fix into the result beat, with output register.
`include "nmea_rmc_sentence_parser_unit_macros.svh"

module nmea_rmc_result_calc import nmea_rmc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                fix_valid,
   input  nmea_rmc_fix_type    fix,
   output logic                in_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output nmea_rmc_result_type rsp_data
);

   logic                fix_vld_ff;
   logic                fix_vld_in;
   nmea_rmc_fix_type    fix_ff;
   logic                mid_vld_ff;
   logic                mid_vld_in;
   nmea_rmc_mid_type    mid_ff;
   nmea_rmc_mid_type    mid_in;
   logic                rsp_vld_ff;
   logic                rsp_vld_in;
   nmea_rmc_result_type rsp_ff;
   nmea_rmc_result_type rsp_in;

   logic        out_adv;
   logic        mid_adv;
   logic        fix_adv;
   logic [48:0] lat_prod;
   logic [48:0] lon_prod;
   logic [34:0] speed_sum;
   logic [24:0] lat_mag;
   logic [27:0] lon_mag;
   logic [58:0] kmh_prod;

   // Bubble-collapsing stage advance
   assign out_adv  = !rsp_vld_ff || rsp_ready;
   assign mid_adv  = !mid_vld_ff || out_adv;
   assign fix_adv  = !fix_vld_ff || mid_adv;
   assign in_ready = fix_adv;

   assign fix_vld_in = fix_adv ? fix_valid : fix_vld_ff;
   assign mid_vld_in = mid_adv ? fix_vld_ff : mid_vld_ff;
   assign rsp_vld_in = out_adv ? mid_vld_ff : rsp_vld_ff;

   // First stage: digit pairs, degree scaling, minute division, knot product
   assign lat_prod  = 49'(fix_ff.lat_minutes) * 49'(MIN60_RECIP);
   assign lon_prod  = 49'(fix_ff.lon_minutes) * 49'(MIN60_RECIP);
   assign speed_sum = 35'(fix_ff.speed_mk) * 35'(KMH_NUMERATOR) + 35'(KMH_ROUND);

   always_comb begin
      mid_in.utc_hour     = pair_value(fix_ff.time_digits[3:0], fix_ff.time_digits[7:4]);
      mid_in.utc_minute   = pair_value(fix_ff.time_digits[11:8], fix_ff.time_digits[15:12]);
      mid_in.utc_second   = pair_value(fix_ff.time_digits[19:16], fix_ff.time_digits[23:20]);
      mid_in.date_day     = pair_value(fix_ff.date_digits[3:0], fix_ff.date_digits[7:4]);
      mid_in.date_month   = pair_value(fix_ff.date_digits[11:8], fix_ff.date_digits[15:12]);
      mid_in.date_year    = YEAR_BASE +
         12'(pair_value(fix_ff.date_digits[19:16], fix_ff.date_digits[23:20]));
      mid_in.lat_deg_e5   = 24'(fix_ff.lat_degrees) * 24'(DEG_SCALE);
      mid_in.lat_min_e5   = 18'(lat_prod >> MIN60_SHIFT);
      mid_in.lat_is_north = fix_ff.hemisphere[0];
      mid_in.lon_deg_e5   = 27'(fix_ff.lon_degrees) * 27'(DEG_SCALE);
      mid_in.lon_min_e5   = 18'(lon_prod >> MIN60_SHIFT);
      mid_in.lon_is_east  = fix_ff.hemisphere[1];
      mid_in.speed_scaled = 29'(speed_sum >> KMH_PRESHIFT);
      mid_in.course_deg   = fix_ff.course;
   end

   // Second stage: signed coordinates and km/h quotient
   // (speed tops out near 31071 km/h, so no clamp is needed)
   assign lat_mag  = 25'(mid_ff.lat_deg_e5) + 25'(mid_ff.lat_min_e5);
   assign lon_mag  = 28'(mid_ff.lon_deg_e5) + 28'(mid_ff.lon_min_e5);
   assign kmh_prod = 59'(mid_ff.speed_scaled) * 59'(KMH_RECIP);

   always_comb begin
      rsp_in.utc_hour     = mid_ff.utc_hour;
      rsp_in.utc_minute   = mid_ff.utc_minute;
      rsp_in.utc_second   = mid_ff.utc_second;
      rsp_in.date_day     = mid_ff.date_day;
      rsp_in.date_month   = mid_ff.date_month;
      rsp_in.date_year    = mid_ff.date_year;
      rsp_in.latitude     = mid_ff.lat_is_north ? lat_mag : -lat_mag;
      rsp_in.lat_is_north = mid_ff.lat_is_north;
      rsp_in.longitude    = mid_ff.lon_is_east ? lon_mag : -lon_mag;
      rsp_in.lon_is_east  = mid_ff.lon_is_east;
      rsp_in.speed_kmh    = 16'(kmh_prod >> KMH_SHIFT);
      rsp_in.course_deg   = mid_ff.course_deg;
   end

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         fix_vld_ff <= 1'b0;
         mid_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         fix_vld_ff <= fix_vld_in;
         mid_vld_ff <= mid_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (fix_adv && fix_valid) begin
         fix_ff <= fix;
      end
      if (mid_adv && fix_vld_ff) begin
         mid_ff <= mid_in;
      end
      if (out_adv && mid_vld_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   `NMEA_RMC_ASSERT_IMPLY(a_full_pipe_stalls, clock, reset,
      rsp_vld_ff && !rsp_ready && mid_vld_ff && fix_vld_ff, !in_ready,
      "input taken while every stage is full and stalled")
   `NMEA_RMC_ASSERT_IMPLY(a_speed_range, clock, reset, rsp_vld_ff,
      rsp_ff.speed_kmh <= 16'd31072, "km/h quotient out of range")
   `NMEA_RMC_ASSERT_IMPLY(a_minute_quotient, clock, reset, mid_vld_ff,
      mid_ff.lat_min_e5 <= 18'd166666 && mid_ff.lon_min_e5 <= 18'd166666,
      "minute quotient out of range")

endmodule

### hw/rtl/nmea_rmc_sentence_parser_unit.sv
// Top level of the NMEA RMC sentence parser: stream ports and result packing.
//
// Parses an RMC-style GPS sentence that arrives one ASCII byte per beat on the
// req_ channel; req_tlast marks the sentence's final byte. A dollar sign restarts
// the sentence, commas and asterisks end fields, and non-digit characters in a
// numeric position read as zero. A byte can be accepted on every clock cycle
// unless req_tready is held low by a full, stalled result path. The beat with
// req_tlast high produces exactly one result beat on the rsp_ channel: the
// captured fix passes two conversion stages, for the minute and km/h reciprocal
// multiplies, and the second stage loads the output register. Results may follow
// each other on consecutive cycles while rsp_tready is high. Up to three results
// can be held (captured fix, middle stage and output register), so input keeps
// flowing while a finished result waits for rsp_tready; once all three are held,
// req_tready follows rsp_tready for every byte until the output beat is taken.
module nmea_rmc_sentence_parser_unit import nmea_rmc_pkg::*; #(
   parameter int MAX_FIELDS = DEFAULT_MAX_FIELDS
) (
   input  logic                  clock,
   input  logic                  reset,
   // Byte channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] char_byte
   input  logic                  req_tlast,   // last_byte
   // Result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [6:0] utc_hour, [13:7] utc_minute, [20:14] utc_second, [27:21] date_day,
   // [34:28] date_month, [46:35] date_year, [71:47] latitude, [72] lat_is_north,
   // [100:73] longitude, [101] lon_is_east, [117:102] speed_kmh,
   // [133:118] course_deg, [135:134] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic                fix_valid;
   nmea_rmc_fix_type    fix;
   nmea_rmc_result_type rsp_data;

   // Field tracking and accumulation
   nmea_rmc_field_tracker #(
      .MAX_FIELDS (MAX_FIELDS)
   ) u_tracker (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .char_byte (req_tdata),
      .last_byte (req_tlast),
      .fix_valid (fix_valid),
      .fix       (fix)
   );

   // Result conversion and output register
   nmea_rmc_result_calc u_calc (
      .clock     (clock),
      .reset     (reset),
      .fix_valid (fix_valid),
      .fix       (fix),
      .in_ready  (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   // Pack result fields, first field lowest
   assign rsp_tdata = {2'b00,
                       rsp_data.course_deg,
                       rsp_data.speed_kmh,
                       rsp_data.lon_is_east,
                       rsp_data.longitude,
                       rsp_data.lat_is_north,
                       rsp_data.latitude,
                       rsp_data.date_year,
                       rsp_data.date_month,
                       rsp_data.date_day,
                       rsp_data.utc_second,
                       rsp_data.utc_minute,
                       rsp_data.utc_hour};

endmodule

### test/tb.sv
// Self-checking testbench for the NMEA RMC sentence parser: directed sentences, then random ones.
`timescale 1ns / 100ps

module tb;
   import nmea_rmc_pkg::*;

   localparam int FIELD_LIMIT  = DEFAULT_MAX_FIELDS;
   localparam int MIN_UNIT     = 100000;   // minutes kept in 1e-5 minute
   localparam int KNOT_UNIT    = 1000;     // speed kept in 1e-3 knot
   localparam int RANDOM_BYTES = 1400;     // directed rows add about 400 more
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 12;
   localparam int ROWS         = 12;
   localparam int REPORT_MAX   = 10;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;   // [7:0] char_byte
   logic                  req_tlast = 1'b0; // last_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [6:0] utc_hour, [13:7] utc_minute, [20:14] utc_second, [27:21] date_day,
   // [34:28] date_month, [46:35] date_year, [71:47] latitude, [72] lat_is_north,
   // [100:73] longitude, [101] lon_is_east, [117:102] speed_kmh,
   // [133:118] course_deg, [135:134] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   nmea_rmc_sentence_parser_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Sentence decoder state, mirrors the block
   int unsigned rmc_field, rmc_pos, rmc_frac;
   bit          rmc_point;
   logic [3:0]  rmc_time [6];
   logic [3:0]  rmc_date [6];
   int unsigned rmc_lat_deg, rmc_lat_min, rmc_lon_deg, rmc_lon_min;
   int unsigned rmc_knots, rmc_course;
   bit          rmc_north, rmc_east;

   nmea_rmc_result_type pending_fixes [$];
   logic [7:0]          line_bytes [$];
   int                  req_gap_pct  = 14;
   int                  rsp_stall_pct = 85;
   int                  mismatches   = 0;
   int                  sent_bytes   = 0;

   string field_names [12] = '{"utc_hour", "utc_minute", "utc_second", "date_day",
      "date_month", "date_year", "latitude", "lat_is_north", "longitude",
      "lon_is_east", "speed_kmh", "course_deg"};
   string hex_digits = "0123456789ABCDEF";

   // Directed sentences; the tail byte goes out with tlast
   string row_text [ROWS] = '{
      "",
      "",
      "",
      "$GPRMC,999999,A,9999.99999,N,99999.99999,E,99999999,99999,999999,,*0",
      "$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6",
      "$GPRMC,081836,A,3751.65,S,14507.36,W,000.0,360.0,130998,011.3,E*6",
      "$GPRMC,1a:2b3c,V,4x07.0y3,n,0z131.q,e,1.2.3,8.4.4,2303",
      "$,000000,A,0000.1234567,N,00000.12345678,E,1.23456,359.999,010100",
      "$,,,,,,,,,,,,,,,,,,,,,,,,1,2",
      "$GPRMC,111111,A,$GPRMC,222222",
      "$,,,1.2.34,N,9",
      ",123456,A,00"};
   logic [7:0] row_tail [ROWS] = '{CHAR_DOLLAR, 8'h00, 8'hFF, CHAR_ZERO, "A", "2", "9",
      CHAR_COMMA, CHAR_STAR, CHAR_STAR, CHAR_COMMA, "5"};
   bit row_typed [ROWS] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0};
   nmea_rmc_result_type row_fix [ROWS];

   function automatic nmea_rmc_result_type make_fix(int h, int m, int s, int d, int mo,
         int y, int lat, bit n, int lon, bit e, int spd, int crs);
      nmea_rmc_result_type f;
      f.utc_hour     = 7'(h);
      f.utc_minute   = 7'(m);
      f.utc_second   = 7'(s);
      f.date_day     = 7'(d);
      f.date_month   = 7'(mo);
      f.date_year    = 12'(y);
      f.latitude     = 25'(lat);
      f.lat_is_north = n;
      f.longitude    = 28'(lon);
      f.lon_is_east  = e;
      f.speed_kmh    = 16'(spd);
      f.course_deg   = 16'(crs);
      return f;
   endfunction

   function automatic nmea_rmc_result_type unpack_rsp(logic [RSP_DATA_W-1:0] d);
      nmea_rmc_result_type f;
      f.utc_hour     = d[6:0];
      f.utc_minute   = d[13:7];
      f.utc_second   = d[20:14];
      f.date_day     = d[27:21];
      f.date_month   = d[34:28];
      f.date_year    = d[46:35];
      f.latitude     = d[71:47];
      f.lat_is_north = d[72];
      f.longitude    = d[100:73];
      f.lon_is_east  = d[101];
      f.speed_kmh    = d[117:102];
      f.course_deg   = d[133:118];
      return f;
   endfunction

   function automatic logic [11:0][31:0] fix_fields(nmea_rmc_result_type f);
      logic [11:0][31:0] v;
      v[0]  = f.utc_hour;
      v[1]  = f.utc_minute;
      v[2]  = f.utc_second;
      v[3]  = f.date_day;
      v[4]  = f.date_month;
      v[5]  = f.date_year;
      v[6]  = f.latitude;
      v[7]  = f.lat_is_north;
      v[8]  = f.longitude;
      v[9]  = f.lon_is_east;
      v[10] = f.speed_kmh;
      v[11] = f.course_deg;
      return v;
   endfunction

   function automatic void rmc_clear();
      rmc_field = 0; rmc_pos = 0; rmc_frac = 0; rmc_point = 1'b0;
      foreach (rmc_time[i]) rmc_time[i] = '0;
      foreach (rmc_date[i]) rmc_date[i] = '0;
      rmc_lat_deg = 0; rmc_lat_min = 0; rmc_lon_deg = 0; rmc_lon_min = 0;
      rmc_knots = 0; rmc_course = 0; rmc_north = 1'b0; rmc_east = 1'b0;
   endfunction

   function automatic int unsigned digit_val(logic [7:0] c);
      return (c >= CHAR_ZERO && c <= CHAR_NINE) ? int'(c - CHAR_ZERO) : 0;
   endfunction

   // Decimal accumulator in 1/unit steps; the first point switches to fraction digits
   function automatic int unsigned add_decimal(int unsigned acc, logic [7:0] c,
         int unsigned unit, int unsigned frac_max, int unsigned cap);
      longint unsigned v;
      int unsigned     scale;
      if (c == CHAR_POINT && !rmc_point) begin
         rmc_point = 1'b1;
         return acc;
      end
      if (!rmc_point) begin
         v = longint'(acc) * 10 + longint'(digit_val(c)) * unit;
      end else if (rmc_frac < frac_max) begin
         scale = unit;
         for (int i = 0; i <= int'(rmc_frac); i++) scale = scale / 10;
         rmc_frac++;
         v = longint'(acc) + longint'(digit_val(c)) * scale;
      end else begin
         return acc;
      end
      return (v > cap) ? cap : int'(v);
   endfunction

   // One accepted byte; on tlast the decoded fix comes out and state clears
   function automatic bit decode_rmc_byte(logic [7:0] c, bit last_flag,
         output nmea_rmc_result_type fix);
      int unsigned         d;
      int unsigned         v;
      logic signed [63:0]  mag, neg;
      longint unsigned     kmh;
      d = digit_val(c);
      fix = '0;
      if (c == CHAR_DOLLAR) begin
         rmc_clear();
      end else if (c == CHAR_COMMA || c == CHAR_STAR) begin
         if (rmc_field < FIELD_LIMIT) rmc_field++;
         rmc_pos = 0; rmc_frac = 0; rmc_point = 1'b0;
      end else if (rmc_field < FIELD_LIMIT) begin
         case (rmc_field)
            FIELD_TIME:     if (rmc_pos < 6) rmc_time[rmc_pos] = 4'(d);
            FIELD_DATE:     if (rmc_pos < 6) rmc_date[rmc_pos] = 4'(d);
            FIELD_LAT: begin
               if (rmc_pos < 2) rmc_lat_deg = rmc_lat_deg * 10 + d;
               else rmc_lat_min = add_decimal(rmc_lat_min, c, MIN_UNIT,
                  MINUTE_FRAC_DIGITS, MINUTES_CAP);
            end
            FIELD_LON: begin
               if (rmc_pos < 3) rmc_lon_deg = rmc_lon_deg * 10 + d;
               else rmc_lon_min = add_decimal(rmc_lon_min, c, MIN_UNIT,
                  MINUTE_FRAC_DIGITS, MINUTES_CAP);
            end
            FIELD_LAT_HEMI: if (rmc_pos == 0 && c == CHAR_N) rmc_north = 1'b1;
            FIELD_LON_HEMI: if (rmc_pos == 0 && c == CHAR_E) rmc_east = 1'b1;
            FIELD_SPEED:    rmc_knots = add_decimal(rmc_knots, c, KNOT_UNIT,
               KNOT_FRAC_DIGITS, MILLIKNOT_CAP);
            FIELD_COURSE: begin
               if (c == CHAR_POINT) begin
                  rmc_point = 1'b1;
               end else if (!rmc_point) begin
                  v = rmc_course * 10 + d;
                  rmc_course = (v > COURSE_CAP) ? COURSE_CAP : v;
               end
            end
            default: ;
         endcase
         if (rmc_pos < CHAR_POS_MAX) rmc_pos++;
      end
      if (!last_flag) return 1'b0;

      fix.utc_hour     = 7'(rmc_time[0] * 10 + rmc_time[1]);
      fix.utc_minute   = 7'(rmc_time[2] * 10 + rmc_time[3]);
      fix.utc_second   = 7'(rmc_time[4] * 10 + rmc_time[5]);
      fix.date_day     = 7'(rmc_date[0] * 10 + rmc_date[1]);
      fix.date_month   = 7'(rmc_date[2] * 10 + rmc_date[3]);
      fix.date_year    = 12'(YEAR_BASE + rmc_date[4] * 10 + rmc_date[5]);
      mag = 64'(rmc_lat_deg) * MIN_UNIT + rmc_lat_min / 60;
      neg = -mag;
      fix.latitude     = rmc_north ? mag[24:0] : neg[24:0];
      fix.lat_is_north = rmc_north;
      mag = 64'(rmc_lon_deg) * MIN_UNIT + rmc_lon_min / 60;
      neg = -mag;
      fix.longitude    = rmc_east ? mag[27:0] : neg[27:0];
      fix.lon_is_east  = rmc_east;
      // knots * 1.852, round half up
      kmh = (64'(rmc_knots) * 1852 + 500000) / 1000000;
      fix.speed_kmh    = (kmh > 65535) ? 16'hFFFF : kmh[15:0];
      fix.course_deg   = 16'(rmc_course);
      rmc_clear();
      return 1'b1;
   endfunction

   // Drive one byte beat, wait for the handshake, then predict
   task automatic put_byte(logic [7:0] c, bit last_flag, bit typed,
         nmea_rmc_result_type typed_fix);
      nmea_rmc_result_type fix;
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last_flag;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (decode_rmc_byte(c, last_flag, fix)) begin
         pending_fixes.push_back(typed ? typed_fix : fix);
      end
   endtask

   // Hold the byte channel until every pending fix has come out
   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      while (pending_fixes.size() != 0) @(posedge clock);
   endtask

   function automatic int pick(int usual, int lo, int hi);
      return ($urandom_range(0, 7) == 0) ? int'($urandom_range(lo, hi)) : usual;
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
   endfunction

   function automatic void add_digits(int n);
      for (int i = 0; i < n; i++) line_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
   endfunction

   function automatic void add_number(int int_digits, int frac_max);
      add_digits(int_digits);
      if ($urandom_range(0, 3) != 0) begin
         line_bytes.push_back(CHAR_POINT);
         add_digits($urandom_range(0, frac_max));
      end
   endfunction

   function automatic void add_hemi(logic [7:0] hit, logic [7:0] other);
      int unsigned k;
      k = $urandom_range(0, 9);
      line_bytes.push_back(CHAR_COMMA);
      if (k < 4) line_bytes.push_back(hit);
      else if (k < 8) line_bytes.push_back(other);
      else if (k == 8) line_bytes.push_back(hit | 8'h20);   // lower case
      line_bytes.push_back(CHAR_COMMA);
   endfunction

   // Well-formed RMC sentence with random content
   function automatic void build_rmc();
      line_bytes.delete();
      add_text("$GPRMC,");
      add_number(pick(6, 0, 8), 3);
      add_text($urandom_range(0, 1) ? ",A," : ",V,");
      add_number(pick(4, 0, 8), 7);
      add_hemi(CHAR_N, "S");
      add_number(pick(5, 0, 9), 7);
      add_hemi(CHAR_E, "W");
      add_number(pick($urandom_range(1, 3), 0, 9), 5);
      line_bytes.push_back(CHAR_COMMA);
      add_number(pick(3, 0, 7), 3);
      line_bytes.push_back(CHAR_COMMA);
      add_digits(pick(6, 0, 8));
      add_text(",,A*");
      line_bytes.push_back(hex_digits[$urandom_range(0, 15)]);
      line_bytes.push_back(hex_digits[$urandom_range(0, 15)]);
   endfunction

   // Result check against the oldest pending fix
   always @(posedge clock) begin : rsp_check
      nmea_rmc_result_type want;
      logic [11:0][31:0]   want_f, got_f;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_fixes.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("tb: unexpected result beat %h", rsp_tdata);
         end else begin
            want   = pending_fixes.pop_front();
            want_f = fix_fields(want);
            got_f  = fix_fields(unpack_rsp(rsp_tdata));
            if (want_f != got_f) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  for (int i = 0; i < 12; i++)
                     if (want_f[i] != got_f[i])
                        $display("tb: %s expected %0h got %0h", field_names[i],
                           want_f[i], got_f[i]);
            end
         end
      end
   end

   // Receiver stalls
   always @(posedge clock) rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);

   // Watchdog: cycles without any beat on either channel
   always @(posedge clock) begin : watchdog
      int quiet;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int  k, cut, phase;
      bit  ends_line;
      rmc_clear();
      row_fix[0] = make_fix(0, 0, 0, 0, 0, 2000, 0, 0, 0, 0, 0, 0);
      row_fix[1] = row_fix[0];
      row_fix[2] = row_fix[0];
      // all nines; the knot accumulator saturates, course saturates
      row_fix[3] = make_fix(99, 99, 99, 99, 99, 2099, 10066666, 1, 100066666, 1,
         31071, 65535);
      for (int i = 4; i < ROWS; i++) row_fix[i] = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed sentences
      for (int r = 0; r < ROWS; r++) begin
         for (int i = 0; i < row_text[r].len(); i++)
            put_byte(row_text[r][i], 1'b0, 1'b0, '0);
         put_byte(row_tail[r], 1'b1, row_typed[r], row_fix[r]);
      end
      hold_until_drained();

      // Random sentences, three idle settings
      phase = 0;
      while (sent_bytes < RANDOM_BYTES) begin
         if (phase == 0 && sent_bytes >= RANDOM_BYTES / 3) begin
            hold_until_drained();
            phase = 1; req_gap_pct = 85; rsp_stall_pct = 14;
         end else if (phase == 1 && sent_bytes >= 2 * RANDOM_BYTES / 3) begin
            hold_until_drained();
            phase = 2; req_gap_pct = 0; rsp_stall_pct = 0;
         end
         k = $urandom_range(0, 99);
         ends_line = 1'b1;
         if (k < 70) begin
            build_rmc();
            if ($urandom_range(0, 2) == 0)
               repeat ($urandom_range(1, 3))
                  line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom_range(0, 255));
         end else if (k < 80) begin
            // sentence cut short
            build_rmc();
            cut = $urandom_range(0, line_bytes.size() - 1);
            line_bytes = line_bytes[0:cut];
         end else if (k < 90) begin
            line_bytes.delete();
            repeat ($urandom_range(1, 30)) line_bytes.push_back(8'($urandom_range(0, 255)));
            ends_line = $urandom_range(0, 1);
         end else begin
            // may run past the field limit
            line_bytes.delete();
            line_bytes.push_back(CHAR_DOLLAR);
            repeat ($urandom_range(15, 40)) begin
               k = $urandom_range(0, 5);
               line_bytes.push_back(k < 2 ? CHAR_COMMA : k == 2 ? CHAR_STAR :
                  CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
         end
         for (int i = 0; i < line_bytes.size(); i++)
            put_byte(line_bytes[i], ends_line && (i == line_bytes.size() - 1), 1'b0, '0);
         sent_bytes += line_bytes.size();
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_fixes.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/nmea_rmc_pkg.sv
hw/rtl/nmea_rmc_field_tracker.sv
hw/rtl/nmea_rmc_result_calc.sv
hw/rtl/nmea_rmc_sentence_parser_unit.sv
test/tb.sv
